@@ rtl/core/mlq_pkg.sv @@
// mlq_pkg: sizes, request and result codes, status codes and the
// controller/datapath command and status structs of the ready queue scheduler.
// No dependencies.
`default_nettype none

package mlq_pkg;

  localparam int LEVELS        = 4;
  localparam int QUEUE_DEPTH   = 8;
  localparam int PROCESS_COUNT = 16;

  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCW = $clog2(LEVELS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int PW  = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;

  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  localparam logic [1:0] REQ_SCHED    = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_MARK     = 2'd2;

  localparam logic [2:0] RES_QUEUED     = 3'd0;
  localparam logic [2:0] RES_BAD_LEVEL  = 3'd1;
  localparam logic [2:0] RES_FULL       = 3'd2;
  localparam logic [2:0] RES_DISPATCHED = 3'd3;
  localparam logic [2:0] RES_REAPED     = 3'd4;
  localparam logic [2:0] RES_NONE       = 3'd5;
  localparam logic [2:0] RES_BAD_STATUS = 3'd6;
  localparam logic [2:0] RES_MARKED     = 3'd7;

  localparam logic [1:0] ST_UNUSED  = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_ZOMBIE  = 2'd3;

  typedef struct packed {
    logic load_req;
    logic do_sched;
    logic do_mark;
    logic lvl_clr;
    logic lvl_inc;
    logic pop;
    logic head_emit;
    logic emit_none;
  } mlq_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       lvl_end;
    logic       lvl_empty;
    logic       head_zombie;
    logic       out_free;
  } mlq_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mlq_in_if.sv @@
// mlq_in_if: request channel, valid/ready with the request fields.
// Depends on nothing.
`default_nettype none

interface mlq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] process_id;
  logic [2:0] priority_level;

  modport source (output valid, req_type, process_id, priority_level, input ready);
  modport sink (input valid, req_type, process_id, priority_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mlq_out_if.sv @@
// mlq_out_if: result channel, valid/ready with the result fields.
// Depends on nothing.
`default_nettype none

interface mlq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [3:0] out_process;
  logic [7:0] quantum_given;
  logic       last_result;

  modport source (output valid, result_kind, out_process, quantum_given, last_result,
                  input ready);
  modport sink (input valid, result_kind, out_process, quantum_given, last_result,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/mlq_ctrl.sv @@
// mlq_ctrl: request sequencer; decodes requests and steps the dispatch scan.
// Depends on mlq_pkg.
`default_nettype none

module mlq_ctrl
  import mlq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mlq_stat_t stat,
  output mlq_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_HEAD   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          REQ_SCHED: begin
            if (stat.out_free) begin
              cmd.do_sched = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          REQ_DISPATCH: begin
            cmd.lvl_clr = 1'b1;
            state_nxt   = S_SCAN;
          end
          REQ_MARK: begin
            if (stat.out_free) begin
              cmd.do_mark = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (stat.lvl_end) begin
          if (stat.out_free) begin
            cmd.emit_none = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (stat.lvl_empty) begin
          cmd.lvl_inc = 1'b1;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat.out_free) begin
          cmd.head_emit = 1'b1;
          state_nxt     = stat.head_zombie ? S_SCAN : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mlq_dp.sv @@
// mlq_dp: queue storage, pointers, process status table, quantum register
// and the result register. Depends on mlq_pkg.
`default_nettype none

module mlq_dp
  import mlq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] req_type,
  input  wire logic [3:0] process_id,
  input  wire logic [2:0] priority_level,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire mlq_cmd_t   cmd,
  output mlq_stat_t       stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      result_kind,
  output logic [3:0]      out_process,
  output logic [7:0]      quantum_given,
  output logic            last_result
);

  logic [3:0]     mem [LEVELS*QUEUE_DEPTH];
  logic [3:0]     rd_r;
  logic [QW-1:0]  heads_r [LEVELS];
  logic [QW-1:0]  tails_r [LEVELS];
  logic [CW-1:0]  counts_r [LEVELS];
  logic [1:0]     status_r [PROCESS_COUNT];
  logic [7:0]     quantum_r;
  logic [1:0]     req_r;
  logic [3:0]     pid_r;
  logic [2:0]     lvl_r;
  logic [LCW-1:0] scan_r;

  logic           out_valid_r;
  logic [2:0]     kind_r, kind_nxt;
  logic [3:0]     proc_r, proc_nxt;
  logic [7:0]     quant_r, quant_nxt;
  logic           last_r, last_nxt;

  logic [LW-1:0]  ix;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           lvl_bad, pid_bad, q_full, head_ok, emit, enq;
  logic [1:0]     head_st;

  function automatic logic [QW-1:0] advance(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ix      = (req_r == REQ_SCHED) ? lvl_r[LW-1:0] : scan_r[LW-1:0];
  assign wr_addr = AW'(ix) * AW'(QUEUE_DEPTH) + AW'(tails_r[ix]);
  assign rd_addr = AW'(ix) * AW'(QUEUE_DEPTH) + AW'(heads_r[ix]);
  assign lvl_bad = (4'(lvl_r) >= 4'(LEVELS));
  assign pid_bad = (5'(pid_r) >= 5'(PROCESS_COUNT));
  assign q_full  = (counts_r[ix] >= CW'(QUEUE_DEPTH));
  assign enq     = cmd.do_sched && !lvl_bad && !pid_bad && !q_full;
  assign head_ok = (5'(rd_r) < 5'(PROCESS_COUNT));
  assign head_st = head_ok ? status_r[rd_r[PW-1:0]] : ST_UNUSED;
  assign emit    = cmd.do_sched | cmd.do_mark | cmd.head_emit | cmd.emit_none;

  assign stat.req         = req_r;
  assign stat.lvl_end     = (scan_r == LCW'(LEVELS));
  assign stat.lvl_empty   = (counts_r[ix] == '0);
  assign stat.head_zombie = (head_st == ST_ZOMBIE);
  assign stat.out_free    = !out_valid_r || out_ready;

  always_comb begin
    kind_nxt  = RES_NONE;
    proc_nxt  = '0;
    quant_nxt = '0;
    last_nxt  = 1'b1;
    if (cmd.do_sched) begin
      proc_nxt = pid_r;
      if (lvl_bad) begin
        kind_nxt = RES_BAD_LEVEL;
      end else if (pid_bad) begin
        kind_nxt = RES_BAD_STATUS;
      end else if (q_full) begin
        kind_nxt = RES_FULL;
      end else begin
        kind_nxt = RES_QUEUED;
      end
    end else if (cmd.do_mark) begin
      proc_nxt = pid_r;
      kind_nxt = pid_bad ? RES_BAD_STATUS : RES_MARKED;
    end else if (cmd.head_emit) begin
      proc_nxt = rd_r;
      case (head_st)
        ST_READY: begin
          kind_nxt  = RES_DISPATCHED;
          quant_nxt = quantum_r;
        end
        ST_ZOMBIE: begin
          kind_nxt = RES_REAPED;
          last_nxt = 1'b0;
        end
        default: kind_nxt = RES_BAD_STATUS;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_addr] <= pid_r;
    end
    if (cmd.pop) begin
      rd_r <= mem[rd_addr];
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req_type;
      pid_r <= process_id;
      lvl_r <= priority_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      for (int i = 0; i < PROCESS_COUNT; i++) begin
        status_r[i] <= ST_UNUSED;
      end
      quantum_r   <= QUANTUM_RESET;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (cmd.lvl_clr) begin
        scan_r <= '0;
      end else if (cmd.lvl_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.do_sched && !lvl_bad && !pid_bad) begin
        status_r[pid_r[PW-1:0]] <= ST_READY;
      end
      if (cmd.do_mark && !pid_bad) begin
        status_r[pid_r[PW-1:0]] <= ST_ZOMBIE;
      end
      if (enq) begin
        tails_r[ix]  <= advance(tails_r[ix]);
        counts_r[ix] <= counts_r[ix] + 1'b1;
      end
      if (cmd.pop) begin
        heads_r[ix]  <= advance(heads_r[ix]);
        counts_r[ix] <= counts_r[ix] - 1'b1;
      end
      if (cmd.head_emit && head_ok) begin
        if (head_st == ST_READY) begin
          status_r[rd_r[PW-1:0]] <= ST_RUNNING;
        end else if (head_st == ST_ZOMBIE) begin
          status_r[rd_r[PW-1:0]] <= ST_UNUSED;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r  <= kind_nxt;
      proc_r  <= proc_nxt;
      quant_r <= quant_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign result_kind   = kind_r;
  assign out_process   = proc_r;
  assign quantum_given = quant_r;
  assign last_result   = last_r;

endmodule

`default_nettype wire

@@ rtl/core/multilevel_ready_queue_scheduler.sv @@
// multilevel_ready_queue_scheduler: top level, joins sequencer and datapath.
// Depends on mlq_pkg, mlq_in_if, mlq_out_if, mlq_ctrl, mlq_dp.
//
//   channel  dir  transfer when        fields
//   in_ch    in   valid & ready        req_type, process_id, priority_level
//   out_ch   out  valid & ready        result_kind, out_process, quantum_given, last_result
//   cfg      in   cfg_we               cfg_wdata (quantum)
//
// schedule and mark: the sequencer takes the request, then decodes it and loads
// the result register. dispatch: take and decode, then step over each empty level
// scanned, close a scan that finds nothing ready, and take each popped head by a
// queue memory read, then a status lookup.
// one request at a time; a full result register holds the sequencer.
// synchronous reset clears pointers, counts and the status table at once.
`default_nettype none

module multilevel_ready_queue_scheduler
  import mlq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  mlq_in_if.sink          in_ch,
  mlq_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  mlq_cmd_t  cmd;
  mlq_stat_t stat;

  mlq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_type       (in_ch.req_type),
    .process_id     (in_ch.process_id),
    .priority_level (in_ch.priority_level),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .result_kind    (out_ch.result_kind),
    .out_process    (out_ch.out_process),
    .quantum_given  (out_ch.quantum_given),
    .last_result    (out_ch.last_result)
  );

endmodule

`default_nettype wire
